### hw/rtl/rccc_pkg.sv
// shared constants, codes and types for the calibrated color classifier
package rccc_pkg;

    localparam int COUNT_BITS = 18;
    localparam int TALLY_BITS = 16;
    localparam int LEVEL_BITS = 8;
    localparam int CLASS_BITS = 3;
    localparam int REG_BITS   = 3;

    localparam logic [CLASS_BITS-1:0] CLS_WHITE   = 3'd0;
    localparam logic [CLASS_BITS-1:0] CLS_RED     = 3'd1;
    localparam logic [CLASS_BITS-1:0] CLS_GREEN   = 3'd2;
    localparam logic [CLASS_BITS-1:0] CLS_BLUE    = 3'd3;
    localparam logic [CLASS_BITS-1:0] CLS_UNKNOWN = 3'd4;

    localparam logic [REG_BITS-1:0] REG_BLACK_RED   = 3'd0;
    localparam logic [REG_BITS-1:0] REG_BLACK_GREEN = 3'd1;
    localparam logic [REG_BITS-1:0] REG_BLACK_BLUE  = 3'd2;
    localparam logic [REG_BITS-1:0] REG_WHITE_RED   = 3'd3;
    localparam logic [REG_BITS-1:0] REG_WHITE_GREEN = 3'd4;
    localparam logic [REG_BITS-1:0] REG_WHITE_BLUE  = 3'd5;
    localparam logic [REG_BITS-1:0] REG_THRESHOLD   = 3'd6;

    localparam logic [LEVEL_BITS-1:0] THRESHOLD_RESET = 8'd95;

    localparam int IN_BITS  = ((3*COUNT_BITS + 7) / 8) * 8;
    localparam int OUT_RAW  = CLASS_BITS + 3*LEVEL_BITS + 3*TALLY_BITS + 1;
    localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;

    typedef struct packed {
        logic                  done;
        logic                  fault;
        logic [LEVEL_BITS-1:0] level;
    } scale_sts_t;

    typedef struct packed {
        logic [CLASS_BITS-1:0] color;
        logic [TALLY_BITS-1:0] red_total;
        logic [TALLY_BITS-1:0] green_total;
        logic [TALLY_BITS-1:0] blue_total;
    } class_res_t;

endpackage

### hw/rtl/rccc_scale.sv
// clamp and scale of one channel with a bit-serial restoring divider
module rccc_scale (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [rccc_pkg::COUNT_BITS-1:0] raw,
    input  logic [rccc_pkg::COUNT_BITS-1:0] blk,
    input  logic [rccc_pkg::COUNT_BITS-1:0] wht,
    output rccc_pkg::scale_sts_t            sts
);
    import rccc_pkg::*;

    localparam int NUM_BITS = COUNT_BITS + LEVEL_BITS;
    localparam int CNT_BITS = $clog2(LEVEL_BITS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic                  fault_reg, fault_next;
    logic [COUNT_BITS-1:0] d_reg, d_next;
    logic [COUNT_BITS-1:0] den_reg, den_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [LEVEL_BITS-1:0] sh_reg, sh_next;

    logic [NUM_BITS-1:0]   num;
    logic [COUNT_BITS:0]   trial;
    logic                  q_bit;

    // d*255 as d*256 - d
    assign num   = {d_reg, {LEVEL_BITS{1'b0}}} - {{LEVEL_BITS{1'b0}}, d_reg};
    assign trial = {rem_reg, sh_reg[LEVEL_BITS-1]};
    assign q_bit = (trial >= {1'b0, den_reg});

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        fault_next = fault_reg;
        d_next     = d_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    fault_next = (wht <= blk);
                    den_next   = wht - blk;
                    if (raw < blk)
                        d_next = '0;
                    else if (raw > wht)
                        d_next = wht - blk;
                    else
                        d_next = raw - blk;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                rem_next   = num[NUM_BITS-1:LEVEL_BITS];
                sh_next    = num[LEVEL_BITS-1:0];
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // one quotient bit per cycle, shifted in behind the numerator bits
                if (q_bit)
                    rem_next = COUNT_BITS'(trial - {1'b0, den_reg});
                else
                    rem_next = trial[COUNT_BITS-1:0];
                sh_next  = {sh_reg[LEVEL_BITS-2:0], q_bit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(LEVEL_BITS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fault_reg <= fault_next;
        d_reg     <= d_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        sh_reg    <= sh_next;
    end

    assign sts.done  = done_reg;
    assign sts.fault = fault_reg;
    assign sts.level = fault_reg ? '0 : sh_reg;

endmodule

### hw/rtl/rccc_class.sv
// color decision on the three levels and the per-class tallies
module rccc_class (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [rccc_pkg::LEVEL_BITS-1:0] r,
    input  logic [rccc_pkg::LEVEL_BITS-1:0] g,
    input  logic [rccc_pkg::LEVEL_BITS-1:0] b,
    input  logic [rccc_pkg::LEVEL_BITS-1:0] threshold,
    input  logic                            update,
    output rccc_pkg::class_res_t            res
);
    import rccc_pkg::*;

    logic [TALLY_BITS-1:0] red_tally_reg, red_tally_next;
    logic [TALLY_BITS-1:0] green_tally_reg, green_tally_next;
    logic [TALLY_BITS-1:0] blue_tally_reg, blue_tally_next;
    logic [CLASS_BITS-1:0] color;

    always_comb
    begin
        if (r > threshold && g > threshold && b > threshold)
            color = CLS_WHITE;
        else if (b < r && g < r)
            color = CLS_RED;
        else if (b <= g && r <= g)
            color = CLS_GREEN;
        else if (r < b && g < b)
            color = CLS_BLUE;
        else
            color = CLS_UNKNOWN;
    end

    always_comb
    begin
        red_tally_next   = red_tally_reg;
        green_tally_next = green_tally_reg;
        blue_tally_next  = blue_tally_reg;
        case (color)
            CLS_RED:   red_tally_next   = red_tally_reg + 1'b1;
            CLS_GREEN: green_tally_next = green_tally_reg + 1'b1;
            CLS_BLUE:  blue_tally_next  = blue_tally_reg + 1'b1;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_tally_reg   <= '0;
            green_tally_reg <= '0;
            blue_tally_reg  <= '0;
        end
        else if (update)
        begin
            red_tally_reg   <= red_tally_next;
            green_tally_reg <= green_tally_next;
            blue_tally_reg  <= blue_tally_next;
        end
    end

    assign res.color       = color;
    assign res.red_total   = red_tally_next;
    assign res.green_total = green_tally_next;
    assign res.blue_total  = blue_tally_next;

endmodule

### hw/rtl/rgb_calibrated_color_classifier_top.sv
// top level of the calibrated rgb color classifier
//
//  channel | direction | handshake                      | word
//  s_axis  | in        | s_axis_tvalid / s_axis_tready  | raw red, green, blue counts
//  m_axis  | out       | m_axis_tvalid / m_axis_tready  | class, levels, totals, fault
//  cfg     | in        | cfg_valid / cfg_ready          | register index and value
//
// m_axis_tvalid rises once a word has gone through the shared scale unit channel by channel
// (start, clamp and multiply by 255, 8 quotient bits one per cycle, level handoff) and has
// been classified into the output register. the next word is taken while the result
// waits, but no new word is taken until the last one has reached the output register;
// a stalled m_axis holds the finished word back in the classify step.
// reset is asynchronous, clears the tallies and loads the calibration defaults.
module rgb_calibrated_color_classifier_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // red_raw, green_raw, blue_raw, zero pad
    input  logic [rccc_pkg::IN_BITS-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // color_class, red_level, green_level, blue_level, red_total, green_total,
    // blue_total, calibration_fault, zero pad
    output logic [rccc_pkg::OUT_BITS-1:0] m_axis_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rccc_pkg::REG_BITS-1:0] cfg_index,
    input  logic [rccc_pkg::COUNT_BITS-1:0] cfg_data
);
    import rccc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_CLASS = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [1:0]            chan_reg, chan_next;
    logic                  out_valid_reg, out_valid_next;

    logic [COUNT_BITS-1:0] black_red_reg, black_green_reg, black_blue_reg;
    logic [COUNT_BITS-1:0] white_red_reg, white_green_reg, white_blue_reg;
    logic [LEVEL_BITS-1:0] threshold_reg;

    logic [COUNT_BITS-1:0] red_raw_reg, green_raw_reg, blue_raw_reg;
    logic [LEVEL_BITS-1:0] red_level_reg, green_level_reg, blue_level_reg;
    logic                  fault_reg;
    logic [OUT_BITS-1:0]   out_data_reg;

    logic                  accept;
    logic                  out_free;
    logic                  load_out;
    logic                  scale_start;
    logic [COUNT_BITS-1:0] sel_raw, sel_blk, sel_wht;
    scale_sts_t            sts;
    class_res_t            res;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign load_out = (state_reg == ST_CLASS) && out_free;
    assign scale_start = (state_reg == ST_START);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        case (chan_reg)
            2'd0:
            begin
                sel_raw = red_raw_reg;
                sel_blk = black_red_reg;
                sel_wht = white_red_reg;
            end
            2'd1:
            begin
                sel_raw = green_raw_reg;
                sel_blk = black_green_reg;
                sel_wht = white_green_reg;
            end
            default:
            begin
                sel_raw = blue_raw_reg;
                sel_blk = black_blue_reg;
                sel_wht = white_blue_reg;
            end
        endcase
    end

    rccc_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scale_start),
        .raw   (sel_raw),
        .blk   (sel_blk),
        .wht   (sel_wht),
        .sts   (sts)
    );

    rccc_class u_class (
        .clk       (clk),
        .rst_n     (rst_n),
        .r         (red_level_reg),
        .g         (green_level_reg),
        .b         (blue_level_reg),
        .threshold (threshold_reg),
        .update    (load_out),
        .res       (res)
    );

    always_comb
    begin
        state_next     = state_reg;
        chan_next      = chan_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    chan_next  = 2'd0;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (sts.done)
                begin
                    if (chan_reg == 2'd2)
                        state_next = ST_CLASS;
                    else
                    begin
                        chan_next  = chan_reg + 2'd1;
                        state_next = ST_START;
                    end
                end
            end
            ST_CLASS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chan_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // calibration registers, index beyond the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_red_reg   <= '0;
            black_green_reg <= '0;
            black_blue_reg  <= '0;
            white_red_reg   <= '1;
            white_green_reg <= '1;
            white_blue_reg  <= '1;
            threshold_reg   <= THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BLACK_RED:   black_red_reg   <= cfg_data;
                REG_BLACK_GREEN: black_green_reg <= cfg_data;
                REG_BLACK_BLUE:  black_blue_reg  <= cfg_data;
                REG_WHITE_RED:   white_red_reg   <= cfg_data;
                REG_WHITE_GREEN: white_green_reg <= cfg_data;
                REG_WHITE_BLUE:  white_blue_reg  <= cfg_data;
                REG_THRESHOLD:   threshold_reg   <= cfg_data[LEVEL_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            red_raw_reg   <= s_axis_tdata[COUNT_BITS-1:0];
            green_raw_reg <= s_axis_tdata[2*COUNT_BITS-1:COUNT_BITS];
            blue_raw_reg  <= s_axis_tdata[3*COUNT_BITS-1:2*COUNT_BITS];
            fault_reg     <= 1'b0;
        end
        else if (state_reg == ST_WAIT && sts.done)
        begin
            if (sts.fault)
                fault_reg <= 1'b1;
            case (chan_reg)
                2'd0:    red_level_reg   <= sts.level;
                2'd1:    green_level_reg <= sts.level;
                default: blue_level_reg  <= sts.level;
            endcase
        end
        if (load_out)
        begin
            out_data_reg <= {{(OUT_BITS-OUT_RAW){1'b0}}, fault_reg,
                             res.blue_total, res.green_total, res.red_total,
                             blue_level_reg, green_level_reg, red_level_reg,
                             res.color};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
